// ===== hdl/bitmap_frame_allocator_defines.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

  localparam int FRAME_W          = 12;
  localparam int FRAME_LIMIT      = 1 << FRAME_W;
  localparam int WORD_W           = 32;
  localparam int BIT_W            = $clog2(WORD_W);
  localparam int FRAME_COUNT_DEF  = 4096;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOTHING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               want_write;
  } bfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic [1:0]         status;
  } bfa_out_t;

  // Word unit results: search, test and update of one bitmap word.
  typedef struct packed {
    logic              full;
    logic [BIT_W-1:0]  free_idx;
    logic              bit_set;
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] clr_word;
  } bfa_wres_t;

endpackage

// ===== hdl/bfa_word_unit.sv =====
module bfa_word_unit
  import bfa_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [BIT_W-1:0]  bit_idx,
  output bfa_wres_t         res
);

  logic [BIT_W-1:0] free_idx;

  // lowest clear bit, priority to bit 0
  always_comb begin
    free_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        free_idx = BIT_W'(i);
      end
    end
  end

  always_comb begin
    res.full     = &word;
    res.free_idx = free_idx;
    res.bit_set  = word[bit_idx];
    res.set_word = word | (WORD_W'(1) << free_idx);
    res.clr_word = word & ~(WORD_W'(1) << bit_idx);
  end

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// First-fit physical frame allocator over a used/free bitmap held in a
// WORD_COUNT x 32 memory (frame f is bit f%32 of word f/32). An allocate
// beat with current_frame zero scans the bitmap from word 0, one word read
// per cycle through the single read port, and sets the lowest clear bit.
// A free beat reads its word, then clears the bit and writes the word back
// if the bit was set. Beats that need no bitmap access (allocate of a page
// that already owns a frame, free of frame zero or of a frame out of range)
// are answered from the idle state. One beat is in flight at a time; the
// next may be taken while the last result still sits in the output
// register. After reset the memory is cleared one word per cycle, all
// WORD_COUNT words, with in_stall held high. Only frames below both
// FRAME_COUNT and 4096 are handed out; a full bitmap returns status 2.
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bfa_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output bfa_out_t out_beat
);

  localparam int WORD_COUNT   = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW           = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SEARCH_LIMIT = (FRAME_COUNT < FRAME_LIMIT) ? FRAME_COUNT : FRAME_LIMIT;
  localparam int SCAN_WORDS   = (SEARCH_LIMIT + WORD_W - 1) / WORD_W;

  localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
  localparam logic [AW-1:0] LAST_SCAN = AW'(SCAN_WORDS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE
  } state_t;

  state_t            state_r,     state_nxt;
  logic [AW-1:0]     clr_addr_r,  clr_addr_nxt;
  logic [AW-1:0]     scan_addr_r, scan_addr_nxt;  // next word to read
  logic              issue_r,     issue_nxt;      // scan reads still to go
  logic              chk_vld_r,   chk_vld_nxt;    // rd_q holds a scanned word
  logic [AW-1:0]     chk_addr_r,  chk_addr_nxt;
  logic [AW-1:0]     free_addr_r, free_addr_nxt;
  logic [BIT_W-1:0]  free_bit_r,  free_bit_nxt;
  logic              kern_r,      kern_nxt;
  logic              wr_r,        wr_nxt;
  logic              out_valid_r, out_valid_nxt;
  bfa_out_t          out_beat_r,  out_beat_nxt;

  // bitmap memory
  logic [WORD_W-1:0] mem [WORD_COUNT];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  logic              in_acc;
  logic [31:0]       cur_ext;
  logic [AW-1:0]     in_word;
  logic              cur_big;
  logic [AW+BIT_W-1:0] found;
  logic              found_ok;
  bfa_wres_t         wres;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign cur_ext  = 32'(in_beat.current_frame);
  assign in_word  = cur_ext[AW+BIT_W-1:BIT_W];
  assign cur_big  = cur_ext >= 32'(FRAME_COUNT);
  assign found    = {chk_addr_r, wres.free_idx};
  assign found_ok = 32'(found) < 32'(SEARCH_LIMIT);

  // the shared search / test / update unit
  bfa_word_unit u_word (
    .word    (rd_q),
    .bit_idx (free_bit_r),
    .res     (wres)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    free_addr_nxt = free_addr_r;
    free_bit_nxt  = free_bit_r;
    kern_nxt      = kern_r;
    wr_nxt        = wr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    mem_we        = 1'b0;
    mem_wa        = clr_addr_r;
    mem_wd        = '0;
    mem_ra        = scan_addr_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // launch the first read along with the accept
        mem_ra = (in_beat.mode == MODE_FREE) ? in_word : '0;
        if (in_acc) begin
          kern_nxt = in_beat.kernel_page;
          wr_nxt   = in_beat.want_write;
          if (in_beat.mode == MODE_ALLOC) begin
            if (in_beat.current_frame != '0) begin
              out_valid_nxt = 1'b1;
              out_beat_nxt  = '{frame_number: in_beat.current_frame, present: 1'b0,
                                writable: 1'b0, user_mode: 1'b0, status: ST_NOTHING};
            end else begin
              state_nxt     = S_ALLOC;
              chk_vld_nxt   = 1'b1;
              chk_addr_nxt  = '0;
              scan_addr_nxt = AW'(1);
              issue_nxt     = (LAST_SCAN != '0);
            end
          end else begin
            if ((in_beat.current_frame == '0) || cur_big) begin
              out_valid_nxt = 1'b1;
              out_beat_nxt  = '{frame_number: '0, present: 1'b0, writable: 1'b0,
                                user_mode: 1'b0, status: ST_NOTHING};
            end else begin
              state_nxt     = S_FREE;
              free_addr_nxt = in_word;
              free_bit_nxt  = in_beat.current_frame[BIT_W-1:0];
            end
          end
        end
      end

      S_ALLOC: begin
        // read word k while checking word k-1
        if (issue_r) begin
          chk_vld_nxt   = 1'b1;
          chk_addr_nxt  = scan_addr_r;
          scan_addr_nxt = scan_addr_r + AW'(1);
          issue_nxt     = (scan_addr_r != LAST_SCAN);
        end
        if (chk_vld_r) begin
          if (!wres.full) begin
            state_nxt     = S_IDLE;
            chk_vld_nxt   = 1'b0;
            issue_nxt     = 1'b0;
            out_valid_nxt = 1'b1;
            if (found_ok) begin
              mem_we       = 1'b1;
              mem_wa       = chk_addr_r;
              mem_wd       = wres.set_word;
              out_beat_nxt = '{frame_number: FRAME_W'(found), present: 1'b1,
                               writable: wr_r, user_mode: !kern_r, status: ST_DONE};
            end else begin
              out_beat_nxt = '{frame_number: '0, present: 1'b0, writable: 1'b0,
                               user_mode: 1'b0, status: ST_FULL};
            end
          end else if (chk_addr_r == LAST_SCAN) begin
            state_nxt     = S_IDLE;
            chk_vld_nxt   = 1'b0;
            issue_nxt     = 1'b0;
            out_valid_nxt = 1'b1;
            out_beat_nxt  = '{frame_number: '0, present: 1'b0, writable: 1'b0,
                              user_mode: 1'b0, status: ST_FULL};
          end
        end
      end

      S_FREE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (wres.bit_set) begin
          mem_we       = 1'b1;
          mem_wa       = free_addr_r;
          mem_wd       = wres.clr_word;
          out_beat_nxt = '{frame_number: '0, present: 1'b0, writable: 1'b0,
                           user_mode: 1'b0, status: ST_DONE};
        end else begin
          out_beat_nxt = '{frame_number: '0, present: 1'b0, writable: 1'b0,
                           user_mode: 1'b0, status: ST_NOTHING};
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    free_addr_r <= free_addr_nxt;
    free_bit_r  <= free_bit_nxt;
    kern_r      <= kern_nxt;
    wr_r        <= wr_nxt;
    out_beat_r  <= out_beat_nxt;
  end

  // no bitmap write while waiting for a request
  `BFA_ASSERT_SAME(a_idle_no_write, state_r == S_IDLE, !mem_we, "bitmap write in idle")
  // scan pipeline must be flushed on leaving the scan
  `BFA_ASSERT_SAME(a_chk_in_alloc, chk_vld_r || issue_r, state_r == S_ALLOC, "stale scan state")
  // a held result must never be overwritten by a new beat
  `BFA_ASSERT_SAME(a_hold_blocks_in, out_valid_r && out_stall, in_stall, "accept over held result")
  // a free beat completes from the free state: the result is registered and the block is back in idle
  `BFA_ASSERT_NEXT(a_free_one_cycle, state_r == S_FREE, out_valid_r && state_r == S_IDLE,
                   "free did not complete")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

import bfa_pkg::*;

// Mirrors the allocator's bitmap and queues up the reply each request must produce.
class frame_alloc_scoreboard;
  logic [WORD_W-1:0] used_map[];
  bfa_out_t          pending_replies[$];
  int frame_total;
  int search_end;
  int held;
  int mismatches;
  int n_granted, n_released, n_full, n_noop, n_checked;

  function new(int frames);
    frame_total = frames;
    search_end  = (frames < FRAME_LIMIT) ? frames : FRAME_LIMIT;
    used_map    = new[(frames + WORD_W - 1) / WORD_W];
    foreach (used_map[i]) used_map[i] = '0;
    held       = 0;
    mismatches = 0;
    n_granted  = 0;
    n_released = 0;
    n_full     = 0;
    n_noop     = 0;
    n_checked  = 0;
  endfunction

  function bit frame_used(int f);
    return used_map[f / WORD_W][f % WORD_W];
  endfunction

  // First fit: lowest clear frame below the search end, -1 if none.
  function int lowest_free();
    int w;
    int f;
    for (w = 0; w < used_map.size(); w++) begin
      if (&used_map[w]) continue;
      for (f = w * WORD_W; f < (w + 1) * WORD_W; f++) begin
        if (f >= search_end) return -1;
        if (!frame_used(f)) return f;
      end
    end
    return -1;
  endfunction

  // Some held nonzero frame picked at random, 0 if there is none.
  function int pick_held();
    int start;
    int i;
    int f;
    start = $urandom_range(1, search_end - 1);
    for (i = 0; i < search_end - 1; i++) begin
      f = 1 + (start - 1 + i) % (search_end - 1);
      if (frame_used(f)) return f;
    end
    return 0;
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  function void note_request(bfa_in_t req);
    bfa_out_t rep;
    int f;
    rep = '0;
    if (req.mode == MODE_ALLOC) begin
      if (req.current_frame != 0) begin
        rep.frame_number = req.current_frame;
        rep.status       = ST_NOTHING;
        n_noop++;
      end else begin
        f = lowest_free();
        if (f < 0) begin
          rep.status = ST_FULL;
          n_full++;
        end else begin
          used_map[f / WORD_W][f % WORD_W] = 1'b1;
          held++;
          rep.frame_number = f[FRAME_W-1:0];
          rep.present      = 1'b1;
          rep.writable     = req.want_write;
          rep.user_mode    = ~req.kernel_page;
          rep.status       = ST_DONE;
          n_granted++;
        end
      end
    end else begin
      f = req.current_frame;
      if (f == 0 || f >= frame_total || !frame_used(f)) begin
        rep.status = ST_NOTHING;
        n_noop++;
      end else begin
        used_map[f / WORD_W][f % WORD_W] = 1'b0;
        held--;
        rep.status = ST_DONE;
        n_released++;
      end
    end
    pending_replies.push_back(rep);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_reply(bfa_out_t got);
    bfa_out_t want;
    if (pending_replies.size() == 0) begin
      $error("unexpected result beat: frame_number %0d, status %0d",
             got.frame_number, got.status);
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    n_checked++;
    compare_field("frame_number", want.frame_number, got.frame_number);
    compare_field("present", want.present, got.present);
    compare_field("writable", want.writable, got.writable);
    compare_field("user_mode", want.user_mode, got.user_mode);
    compare_field("status", want.status, got.status);
  endfunction
endclass

module testbench;

  localparam int FRAME_TOTAL = FRAME_COUNT_DEF;
  // About 750 requests, even with the longest scans and stalls, finish well
  // inside the limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 160;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  bfa_in_t  in_beat   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  bfa_out_t out_beat;

  // Idling on both sides is allowed only while this is set.
  bit idle_on = 1'b1;
  int cycles  = 0;
  int stall_left = 0;

  frame_alloc_scoreboard sb = new(FRAME_TOTAL);

  bitmap_frame_allocator #(
    .FRAME_COUNT(FRAME_TOTAL)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake or a runaway scan ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, sb.pending());
      $display("bitmap_frame_allocator: mismatch");
      $finish;
    end
  end

  // Receiver backpressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (!idle_on || !rst_n) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor. Values read right after the edge are the ones the edge sampled,
  // since every driver here and in the block updates through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_reply(out_beat);
    end
  end

  function automatic bfa_in_t make_req(logic mode, int cur, bit kern, bit wr);
    bfa_in_t r;
    r.mode          = mode;
    r.current_frame = cur[FRAME_W-1:0];
    r.kernel_page   = kern;
    r.want_write    = wr;
    return r;
  endfunction

  // Present one request beat and hold it until taken. Valid stays high after
  // acceptance so back-to-back beats need no low cycle; it is dropped only
  // when a gap or a pause follows.
  task automatic send_request(bfa_in_t req);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic alloc_page(int cur);
    send_request(make_req(MODE_ALLOC, cur, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))));
  endtask

  task automatic free_page(int cur);
    send_request(make_req(MODE_FREE, cur, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))));
  endtask

  // Sender stops until every reply has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly fresh allocations and frees of owned frames, salted with
  // frees of arbitrary frames and allocs for pages that already own one.
  task automatic random_request();
    int pick;
    int f;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      alloc_page(0);
    end else if (pick < 75) begin
      f = sb.pick_held();
      free_page(f != 0 ? f : $urandom_range(0, FRAME_LIMIT - 1));
    end else if (pick < 87) begin
      free_page($urandom_range(0, FRAME_LIMIT - 1));
    end else begin
      alloc_page($urandom_range(1, FRAME_LIMIT - 1));
    end
  endtask

  initial begin
    int chunk;
    int i;
    int f;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its bitmap memory after reset with in_stall high;
    // the first beat simply waits that out.

    // Directed: first fit from an empty map, flag mapping, no-op cases.
    send_request(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));     // frame zero handed out first
    send_request(make_req(MODE_ALLOC, 0, 1'b1, 1'b0));
    send_request(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));
    send_request(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));
    send_request(make_req(MODE_ALLOC, 4095, 1'b1, 1'b1));  // page already owns a frame
    send_request(make_req(MODE_ALLOC, 1, 1'b0, 1'b1));
    send_request(make_req(MODE_ALLOC, 12'hAAA, 1'b1, 1'b0));
    send_request(make_req(MODE_ALLOC, 12'h555, 1'b0, 1'b1));
    send_request(make_req(MODE_FREE, 0, 1'b1, 1'b1));      // frame zero held yet unfreeable
    send_request(make_req(MODE_FREE, 4095, 1'b1, 1'b1));   // bit already clear
    send_request(make_req(MODE_FREE, 2, 1'b0, 1'b0));
    send_request(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));     // hole at 2 reused
    send_request(make_req(MODE_FREE, 2, 1'b1, 1'b0));
    send_request(make_req(MODE_FREE, 2, 1'b0, 1'b1));      // double free
    send_request(make_req(MODE_FREE, 1, 1'b0, 1'b0));
    send_request(make_req(MODE_FREE, 3, 1'b1, 1'b1));
    send_request(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));
    send_request(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));
    send_request(make_req(MODE_FREE, 12'h555, 1'b0, 1'b0));
    send_request(make_req(MODE_FREE, 12'hAAA, 1'b1, 1'b1));

    // Random traffic in chunks; every fourth chunk runs without idling,
    // and once in the middle the sender waits for the pipe to drain.
    for (chunk = 0; chunk < 13; chunk++) begin
      idle_on = (chunk % 4 != 3);
      for (i = 0; i < 50; i++) random_request();
      if (chunk == 7) wait_drained();
    end

    // Last part, no idling: free/double-free/reallocate churn back to back.
    idle_on = 1'b0;
    for (i = 0; i < 20; i++) begin
      f = sb.pick_held();
      free_page(f);
      free_page(f);
      alloc_page(0);
      alloc_page(0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d replies: %0d frames granted, %0d released, %0d no-op requests",
             sb.n_checked, sb.n_granted, sb.n_released, sb.n_noop);
    $display("random stalls on both sides, one full drain, gap-free tail; %0d frames held",
             sb.held);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bitmap_frame_allocator: match");
    end else begin
      $display("bitmap_frame_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bfa_pkg.sv
hdl/bfa_word_unit.sv
hdl/bitmap_frame_allocator.sv
verif/testbench.sv
